[rtl/mss_pkg.sv]
// ----------------------------------------------------------------------------
// mss_pkg: shared types and constants of the seven-segment scanner
// Item and result structs, operation codes and the digit glyph table.
// ----------------------------------------------------------------------------
`default_nettype none

package mss_pkg;

   localparam int DIGIT_COUNT_DEFAULT = 4;
   localparam int VALUE_WIDTH = 14;
   localparam int DIGIT_WIDTH = 4;
   localparam int ENABLE_WIDTH = 4;
   localparam int SEGMENT_WIDTH = 8;
   localparam int SHOWN_WIDTH = 2;

   typedef enum logic [0:0] {
      OP_LOAD = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [VALUE_WIDTH-1:0] value;
   } req_type;

   typedef struct packed {
      logic [ENABLE_WIDTH-1:0]  digit_enable;
      logic [SEGMENT_WIDTH-1:0] segments;
      logic [SHOWN_WIDTH-1:0]   shown_position;
   } rsp_type;

   // active-high pattern g,f,e,d,c,b,a
   function automatic logic [6:0] glyph(input logic [DIGIT_WIDTH-1:0] digit);
      logic [6:0] pattern;
      case (digit)
         4'd0:    pattern = 7'b0111111;
         4'd1:    pattern = 7'b0000110;
         4'd2:    pattern = 7'b1011011;
         4'd3:    pattern = 7'b1001111;
         4'd4:    pattern = 7'b1100110;
         4'd5:    pattern = 7'b1101101;
         4'd6:    pattern = 7'b1111101;
         4'd7:    pattern = 7'b0000111;
         4'd8:    pattern = 7'b1111111;
         4'd9:    pattern = 7'b1101111;
         default: pattern = 7'b0000000;
      endcase
      return pattern;
   endfunction

endpackage

`default_nettype wire

[rtl/mss_front.sv]
// ----------------------------------------------------------------------------
// mss_front: item intake and decimal split
// Clamps load values and peels one decimal digit per pipeline stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_front #(
   parameter int DIGIT_COUNT = mss_pkg::DIGIT_COUNT_DEFAULT
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               req_valid,
   output logic                                               req_ready,
   input  mss_pkg::req_type                                   req_data,
   output logic                                               out_valid,
   input  logic                                               out_ready,
   output mss_pkg::op_type                                    out_op,
   output logic [DIGIT_COUNT-1:0][mss_pkg::DIGIT_WIDTH-1:0]   out_digits
);
   import mss_pkg::*;

   function automatic int value_limit(input int count);
      int limit;
      limit = 1;
      for (int i = 0; i < count; i++) begin
         limit = limit * 10;
      end
      return limit - 1;
   endfunction

   localparam int ValueLimit = value_limit(DIGIT_COUNT);
   localparam int RecipWidth = 16;
   localparam logic [RecipWidth-1:0] DivRecip = 16'd52429;
   localparam int DivShift = 19;
   localparam int ProdWidth = VALUE_WIDTH + RecipWidth;

   typedef logic [DIGIT_COUNT-1:0][DIGIT_WIDTH-1:0] digits_type;

   logic [DIGIT_COUNT-1:0]  valid_ff;
   op_type                  op_ff     [DIGIT_COUNT];
   logic [VALUE_WIDTH-1:0]  rest_ff   [DIGIT_COUNT];
   digits_type              digits_ff [DIGIT_COUNT];

   logic                    advance;
   logic [VALUE_WIDTH-1:0]  value_clamped;

   assign advance = !valid_ff[DIGIT_COUNT-1] || out_ready;
   assign req_ready = advance;

   assign value_clamped = ({18'd0, req_data.value} > 32'(ValueLimit)) ?
                          VALUE_WIDTH'(ValueLimit) : req_data.value;

   for (genvar k = 0; k < DIGIT_COUNT; k++) begin : g_stage
      logic                    src_valid;
      op_type                  src_op;
      logic [VALUE_WIDTH-1:0]  src_rest;
      digits_type              src_digits;
      logic [ProdWidth-1:0]    product;
      logic [VALUE_WIDTH-1:0]  quot;
      logic [VALUE_WIDTH-1:0]  rem_full;
      digits_type              digits_in;

      if (k == 0) begin : g_first
         assign src_valid  = req_valid;
         assign src_op     = req_data.op;
         assign src_rest   = value_clamped;
         assign src_digits = '0;
      end else begin : g_next
         assign src_valid  = valid_ff[k-1];
         assign src_op     = op_ff[k-1];
         assign src_rest   = rest_ff[k-1];
         assign src_digits = digits_ff[k-1];
      end

      // divide by ten through the reciprocal, exact below 2^14
      always_comb begin
         product = ProdWidth'(src_rest) * ProdWidth'(DivRecip);
         quot = VALUE_WIDTH'(product >> DivShift);
         rem_full = src_rest - (quot << 3) - (quot << 1);
         digits_in = src_digits;
         digits_in[k] = rem_full[DIGIT_WIDTH-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (advance) begin
            valid_ff[k] <= src_valid;
         end
      end

      always_ff @(posedge clock) begin
         if (advance) begin
            op_ff[k]     <= src_op;
            rest_ff[k]   <= quot;
            digits_ff[k] <= digits_in;
         end
      end
   end

   assign out_valid  = valid_ff[DIGIT_COUNT-1];
   assign out_op     = op_ff[DIGIT_COUNT-1];
   assign out_digits = digits_ff[DIGIT_COUNT-1];

endmodule

`default_nettype wire

[rtl/mss_queue.sv]
// ----------------------------------------------------------------------------
// mss_queue: short decoupling queue
// Register-based first-in first-out buffer between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  logic [WIDTH-1:0] in_data,
   output logic             out_valid,
   input  logic             out_ready,
   output logic [WIDTH-1:0] out_data
);
   localparam int PtrWidth = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CountWidth = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]      entry_ff [DEPTH];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [CountWidth-1:0] count_ff, count_in;
   logic                  push;
   logic                  pop;

   assign in_ready  = (count_ff != CountWidth'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_data  = entry_ff[rd_ptr_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrWidth'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= in_data;
      end
   end

endmodule

`default_nettype wire

[rtl/mss_back.sv]
// ----------------------------------------------------------------------------
// mss_back: display state and result register
// Holds digits and scan position, applies loads and ticks, drives results.
// ----------------------------------------------------------------------------
`default_nettype none

module mss_back #(
   parameter int DIGIT_COUNT = mss_pkg::DIGIT_COUNT_DEFAULT
) (
   input  logic                                               clock,
   input  logic                                               reset,
   input  logic                                               in_valid,
   output logic                                               in_ready,
   input  mss_pkg::op_type                                    in_op,
   input  logic [DIGIT_COUNT-1:0][mss_pkg::DIGIT_WIDTH-1:0]   in_digits,
   output logic                                               rsp_valid,
   input  logic                                               rsp_ready,
   output mss_pkg::rsp_type                                   rsp_data
);
   import mss_pkg::*;

   localparam int PosWidth = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
   localparam int CountWidth = PosWidth + 1;

   typedef logic [DIGIT_COUNT-1:0][DIGIT_WIDTH-1:0] digits_type;

   digits_type             store_ff, store_in;
   logic [PosWidth-1:0]    top_ff, top_in;
   logic [PosWidth-1:0]    scan_ff, scan_in;
   logic [PosWidth-1:0]    load_top;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;
   logic                   take;
   logic [DIGIT_WIDTH-1:0] shown_digit;
   logic [7:0]             pos_wide;

   assign in_ready = !rsp_valid_ff || rsp_ready;
   assign take = in_valid && in_ready;

   // highest nonzero position of the incoming digits
   always_comb begin
      load_top = '0;
      for (int i = 0; i < DIGIT_COUNT; i++) begin
         if (in_digits[i] != '0) begin
            load_top = PosWidth'(i);
         end
      end
   end

   always_comb begin
      store_in = store_ff;
      top_in = top_ff;
      scan_in = scan_ff;
      if (take) begin
         if (in_op == OP_LOAD) begin
            store_in = in_digits;
            top_in = load_top;
            scan_in = '0;
         end else if ((scan_ff >= top_ff) ||
                      (({1'b0, scan_ff} + 1'b1) >= CountWidth'(DIGIT_COUNT))) begin
            scan_in = '0;
         end else begin
            scan_in = scan_ff + 1'b1;
         end
      end

      shown_digit = store_in[scan_in];
      pos_wide = 8'(scan_in);
      for (int i = 0; i < ENABLE_WIDTH; i++) begin
         rsp_data_in.digit_enable[i] = (i < DIGIT_COUNT) && (pos_wide == 8'(i));
      end
      rsp_data_in.segments = ~{1'b0, glyph(shown_digit)};
      rsp_data_in.shown_position = pos_wide[SHOWN_WIDTH-1:0];

      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (take) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         store_ff <= '0;
         top_ff <= '0;
         scan_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         store_ff <= store_in;
         top_ff <= top_in;
         scan_ff <= scan_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_data_ff;

endmodule

`default_nettype wire

[rtl/multiplexed_seven_segment_scanner_top.sv]
// ----------------------------------------------------------------------------
// multiplexed_seven_segment_scanner_top: multiplexed seven-segment scanner
// Items on req_ either load a value (op = load) or advance the scan
// (op = tick). Every item gives one result on rsp_: a one-hot digit enable,
// the active-low segment lines of that digit and its position.
// A load splits the value into decimal digits, one digit per front stage,
// and restarts the scan at the units digit; ticks walk up to the highest
// nonzero position and wrap, so leading zeros stay dark.
// Each item passes through the DIGIT_COUNT stage split pipeline, the queue
// and the result register on its way to a result.
// Throughput: one item per cycle, loads and ticks alike, while req_ready holds.
// Reset empties the pipeline and queue and shows "0" on the units digit.
// A stalled receiver holds the result; the queue and pipeline keep taking
// items until the queue and last front stage are full; then req_ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module multiplexed_seven_segment_scanner_top #(
   parameter int DIGIT_COUNT = mss_pkg::DIGIT_COUNT_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mss_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mss_pkg::rsp_type rsp_data
);
   import mss_pkg::*;

   localparam int EntryWidth = 1 + DIGIT_COUNT * DIGIT_WIDTH;
   localparam int QueueDepth = 2;

   typedef logic [DIGIT_COUNT-1:0][DIGIT_WIDTH-1:0] digits_type;

   logic                  front_valid;
   logic                  q_in_ready;
   op_type                front_op;
   digits_type            front_digits;
   logic                  q_out_valid;
   logic                  back_ready;
   logic [EntryWidth-1:0] q_out_data;
   op_type                back_op;
   digits_type            back_digits;

   mss_front #(
      .DIGIT_COUNT(DIGIT_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .out_valid  (front_valid),
      .out_ready  (q_in_ready),
      .out_op     (front_op),
      .out_digits (front_digits)
   );

   mss_queue #(
      .WIDTH(EntryWidth),
      .DEPTH(QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (front_valid),
      .in_ready  (q_in_ready),
      .in_data   ({front_op, front_digits}),
      .out_valid (q_out_valid),
      .out_ready (back_ready),
      .out_data  (q_out_data)
   );

   assign back_op = op_type'(q_out_data[EntryWidth-1]);
   assign back_digits = q_out_data[EntryWidth-2:0];

   mss_back #(
      .DIGIT_COUNT(DIGIT_COUNT)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (q_out_valid),
      .in_ready  (back_ready),
      .in_op     (back_op),
      .in_digits (back_digits),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

`ifndef SYNTHESIS
   a_stall_means_full: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> !q_in_ready && q_out_valid)
      else $error("intake stalled while queue has room");

   a_load_restarts: assert property (@(posedge clock) disable iff (reset)
      q_out_valid && back_ready && (back_op == OP_LOAD) |=>
         rsp_valid && (rsp_data.shown_position == 2'd0) &&
         (rsp_data.digit_enable == 4'b0001))
      else $error("load did not restart scan at units digit");

   a_enable_matches_position: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.digit_enable != 4'd0) |->
         (rsp_data.digit_enable == (4'b0001 << rsp_data.shown_position)))
      else $error("digit enable disagrees with shown position");
`endif

endmodule

`default_nettype wire

[tb/tb_multiplexed_seven_segment_scanner_top.sv]
// ----------------------------------------------------------------------------
// tb_multiplexed_seven_segment_scanner_top: scanner self-checking testbench
// A short table of directed loads and ticks, then about fourteen hundred
// random items in load-and-scan sequences with some noise in between. A
// scoreboard model of digit store and scan position predicts each result the
// table does not fix; all are compared field by field with what comes back.
// Both sides idle at random, the receiver holds off once long enough to fill
// the block, and the sender twice waits until every result is back.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_multiplexed_seven_segment_scanner_top;

   timeunit 1ns;
   timeprecision 1ps;

   import mss_pkg::*;

   localparam int DIGITS = 4;
   localparam int MAX_VALUE = 9999;
   localparam int PIPE_DEPTH = DIGITS + 1;
   localparam int STALL_LIMIT = 3000;
   localparam int HOLD_CYCLES = 80;
   localparam int PHASE_ITEMS = 475;
   localparam int ROW_COUNT = 25;

   // segments lit, pattern g,f,e,d,c,b,a
   localparam logic [6:0] SEGMENTS_LIT [10] = '{
      7'h3F, 7'h06, 7'h5B, 7'h4F, 7'h66, 7'h6D, 7'h7D, 7'h07, 7'h7F, 7'h6F
   };

   typedef struct packed {
      op_type      op;
      logic [13:0] value;
      logic        fixed;
      rsp_type     shown;
   } stim_row_type;

   localparam rsp_type NONE_GIVEN = '0;
   localparam rsp_type UNITS_ZERO = '{4'b0001, 8'hC0, 2'd0};
   localparam rsp_type UNITS_NINE = '{4'b0001, 8'h90, 2'd0};
   localparam rsp_type THOUSANDS_NINE = '{4'b1000, 8'h90, 2'd3};

   localparam stim_row_type DIRECTED_ROWS [ROW_COUNT] = '{
      '{OP_TICK, 14'd0,     1'b1, UNITS_ZERO},
      '{OP_LOAD, 14'd0,     1'b1, UNITS_ZERO},
      '{OP_TICK, 14'd0,     1'b1, UNITS_ZERO},
      '{OP_LOAD, 14'd9999,  1'b1, UNITS_NINE},
      '{OP_TICK, 14'h3FFF,  1'b0, NONE_GIVEN},
      '{OP_TICK, 14'd0,     1'b0, NONE_GIVEN},
      '{OP_TICK, 14'd0,     1'b1, THOUSANDS_NINE},
      '{OP_TICK, 14'h2AAA,  1'b1, UNITS_NINE},
      '{OP_LOAD, 14'h3FFF,  1'b1, UNITS_NINE},
      '{OP_LOAD, 14'd10000, 1'b1, UNITS_NINE},
      '{OP_LOAD, 14'd1000,  1'b1, UNITS_ZERO},
      '{OP_TICK, 14'h1555,  1'b0, NONE_GIVEN},
      '{OP_TICK, 14'd0,     1'b0, NONE_GIVEN},
      '{OP_TICK, 14'd0,     1'b0, NONE_GIVEN},
      '{OP_TICK, 14'd0,     1'b0, NONE_GIVEN},
      '{OP_LOAD, 14'd10,    1'b1, UNITS_ZERO},
      '{OP_TICK, 14'd0,     1'b0, NONE_GIVEN},
      '{OP_TICK, 14'd0,     1'b1, UNITS_ZERO},
      '{OP_LOAD, 14'd1234,  1'b0, NONE_GIVEN},
      '{OP_TICK, 14'd0,     1'b0, NONE_GIVEN},
      '{OP_LOAD, 14'd5678,  1'b0, NONE_GIVEN},
      '{OP_TICK, 14'd0,     1'b0, NONE_GIVEN},
      '{OP_TICK, 14'd0,     1'b0, NONE_GIVEN},
      '{OP_TICK, 14'd0,     1'b0, NONE_GIVEN},
      '{OP_TICK, 14'd0,     1'b0, NONE_GIVEN}
   };

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   logic [3:0] digit_model [DIGITS];
   logic [1:0] top_model;
   logic [1:0] scan_model;
   rsp_type    expected_display [$];

   int unsigned req_idle_pct = 26;
   int unsigned rsp_idle_pct = 57;
   bit          hold_request = 1'b0;
   int unsigned error_count = 0;
   int unsigned results_checked = 0;
   int unsigned loads_sent = 0;
   int unsigned ticks_sent = 0;
   int unsigned saturated_loads = 0;
   int unsigned input_stall_cycles = 0;

   multiplexed_seven_segment_scanner_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   function automatic rsp_type predict_display(req_type item);
      int unsigned remaining;
      rsp_type     shown;
      if (item.op == OP_LOAD) begin
         remaining = (item.value > MAX_VALUE) ? MAX_VALUE : item.value;
         top_model = 2'd0;
         for (int i = 0; i < DIGITS; i++) begin
            digit_model[i] = 4'(remaining % 10);
            remaining = remaining / 10;
            if (digit_model[i] != 4'd0) begin
               top_model = 2'(i);
            end
         end
         scan_model = 2'd0;
      end else if (scan_model >= top_model || scan_model == 2'(DIGITS - 1)) begin
         scan_model = 2'd0;
      end else begin
         scan_model = scan_model + 2'd1;
      end
      shown.digit_enable = 4'b0001 << scan_model;
      shown.segments = {1'b1, ~SEGMENTS_LIT[digit_model[scan_model]]};
      shown.shown_position = scan_model;
      return shown;
   endfunction

   function automatic logic [13:0] pick_value();
      case ($urandom_range(0, 5))
         0: return 14'($urandom_range(0, 9));
         1: return 14'($urandom_range(10, 99));
         2: return 14'($urandom_range(100, 999));
         3: return 14'($urandom_range(1000, MAX_VALUE));
         4: return 14'($urandom_range(MAX_VALUE + 1, 16383));
         default: return 14'($urandom);
      endcase
   endfunction

   task automatic send_request(req_type item, logic fixed, rsp_type fixed_shown);
      rsp_type predicted;
      @(negedge clock);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do begin
         @(posedge clock);
      end while (!req_ready);
      predicted = predict_display(item);
      expected_display.push_back(fixed ? fixed_shown : predicted);
      if (item.op == OP_LOAD) begin
         loads_sent++;
         if (item.value > MAX_VALUE) begin
            saturated_loads++;
         end
      end else begin
         ticks_sent++;
      end
   endtask

   task automatic send_sequences(int unsigned count);
      int unsigned sent;
      int unsigned ticks;
      req_type     item;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 85) begin
            item.op = OP_LOAD;
            item.value = pick_value();
            send_request(item, 1'b0, NONE_GIVEN);
            sent++;
            ticks = $urandom_range(0, 9);
            repeat (ticks) begin
               item.op = OP_TICK;
               item.value = 14'($urandom);
               send_request(item, 1'b0, NONE_GIVEN);
               sent++;
            end
         end else begin
            item.op = op_type'($urandom_range(0, 1));
            item.value = 14'($urandom);
            send_request(item, 1'b0, NONE_GIVEN);
            sent++;
         end
      end
   endtask

   task automatic wait_all_shown();
      while (expected_display.size() != 0) begin
         @(posedge clock);
      end
   endtask

   task automatic report_field(string field, int unsigned want, int unsigned got);
      $display("%0t ns: %s mismatch, expected 0x%0h actual 0x%0h", $time, field, want, got);
      error_count++;
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
         end else begin
            rsp_ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
         end
      end
   end

   // result checker, also counting input stalls
   initial begin
      rsp_type want;
      forever begin
         @(posedge clock);
         if (!reset && req_valid && !req_ready) begin
            input_stall_cycles++;
         end
         if (!reset && rsp_valid && rsp_ready) begin
            if (expected_display.size() == 0) begin
               $display("%0t ns: unexpected transfer, expected none actual %p", $time,
                        rsp_data);
               error_count++;
            end else begin
               want = expected_display.pop_front();
               results_checked++;
               if (rsp_data.digit_enable !== want.digit_enable) begin
                  report_field("digit_enable", want.digit_enable, rsp_data.digit_enable);
               end
               if (rsp_data.segments !== want.segments) begin
                  report_field("segments", want.segments, rsp_data.segments);
               end
               if (rsp_data.shown_position !== want.shown_position) begin
                  report_field("shown_position", want.shown_position,
                               rsp_data.shown_position);
               end
            end
         end
      end
   end

   // watchdog on cycles without any transfer
   initial begin
      int unsigned quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("%0t ns: no transfer for %0d cycles", $time, STALL_LIMIT);
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      req_type item;
      for (int i = 0; i < DIGITS; i++) begin
         digit_model[i] = 4'd0;
      end
      top_model = 2'd0;
      scan_model = 2'd0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      for (int row = 0; row < ROW_COUNT; row++) begin
         item.op = DIRECTED_ROWS[row].op;
         item.value = DIRECTED_ROWS[row].value;
         send_request(item, DIRECTED_ROWS[row].fixed, DIRECTED_ROWS[row].shown);
      end

      send_sequences(PHASE_ITEMS);

      req_idle_pct = 57;
      rsp_idle_pct = 26;
      send_sequences(PHASE_ITEMS);

      @(negedge clock);
      req_valid <= 1'b0;
      wait_all_shown();
      req_idle_pct = 0;
      rsp_idle_pct = 0;
      hold_request = 1'b1;
      send_sequences(PHASE_ITEMS);

      @(negedge clock);
      req_valid <= 1'b0;
      wait_all_shown();
      repeat (PIPE_DEPTH + 10) @(posedge clock);

      $display("covered %0d loads (%0d above the display range) and %0d ticks",
               loads_sent, saturated_loads, ticks_sent);
      $display("checked %0d results, input stalled for %0d cycles",
               results_checked, input_stall_cycles);
      if (error_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

`default_nettype wire
